// ----- sv/swrl_pkg.sv -----
package swrl_pkg;

   localparam int MAP_DIM      = 64;
   localparam int COORD_W      = 6;
   localparam int DIM_W        = 7;
   localparam int ADDR_W       = 12;
   localparam int TILE_COUNT   = 4096;
   localparam int REGION_W     = 13;
   localparam int PTR_W        = 13;
   localparam int POS_W        = 8;
   localparam int OFF_W        = 5;
   localparam int DIST_W       = 4;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;
   localparam int CSR_IDX_W    = 2;

   localparam logic [REGION_W-1:0] REGION_NONE = {REGION_W{1'b1}};
   localparam logic [REGION_W-1:0] REGION_MAX  = 13'd4095;
   localparam logic signed [OFF_W-1:0] SHORE_REACH  = 5'sd2;
   localparam logic signed [OFF_W-1:0] WINDOW_REACH = 5'sd2;
   localparam logic signed [OFF_W-1:0] ENTRY_RADIUS = 5'sd4;

   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

   typedef enum logic {
      OP_LOAD,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic                 sea;
      logic                 land;
   } item_type;

   typedef struct packed {
      logic [DIM_W-1:0]     width;
      logic [DIM_W-1:0]     height;
      logic                 write;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic                 inmap;
      logic                 center;
      logic [DIST_W-1:0]    span;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
   } pend_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SH,
      S_LB_RD,
      S_LB_CHK,
      S_Q_RD,
      S_Q_DAT,
      S_NB_RD,
      S_NB_CHK,
      S_WIN,
      S_ENT,
      S_OUT
   } state_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAP_DIM)) begin
         r = DIM_W'(MAP_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic pos_in_map(input logic signed [POS_W-1:0] pc,
                                       input logic signed [POS_W-1:0] pr,
                                       input logic [DIM_W-1:0] w,
                                       input logic [DIM_W-1:0] h);
      return (pc >= 0) && (pr >= 0) &&
             (pc < signed'({1'b0, w})) && (pr < signed'({1'b0, h}));
   endfunction

endpackage

// ----- sv/shallow_water_region_labeler_top.sv -----
// channel   direction  handshake           payload
// req       in         push / full         cmd, col, row, tile_sea, tile_land
// rsp       out        pop / empty         own_region, window_region, entry_found/col/row
// csr       in         csr_valid/csr_ready csr_index, csr_data (map_width, map_height)
//
// a load is written to the tile ram straight from idle; a query with fresh labels scans
// the 5x5 window and then growing entry rings, one region-ram read per tile
// the first query after a load or a map_width/map_height write first rebuilds labels:
// a shore test over the 5x5 neighbourhood of each in-map tile, then a raster scan
// with a 4-neighbour flood fill from each unlabelled shallow tile
// synchronous active-high reset; maps are undefined until loaded, labels start stale
// a 4-beat input queue and a result register let either side stall on its own
module shallow_water_region_labeler_top import swrl_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_cmd,
   input  logic [COORD_W-1:0]          req_col,
   input  logic [COORD_W-1:0]          req_row,
   input  logic                        req_tile_sea,
   input  logic                        req_tile_land,
   output logic                        empty,
   input  logic                        pop,
   output logic signed [REGION_W-1:0]  rsp_own_region,
   output logic signed [REGION_W-1:0]  rsp_window_region,
   output logic                        rsp_entry_found,
   output logic [COORD_W-1:0]          rsp_entry_col,
   output logic [COORD_W-1:0]          rsp_entry_row,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DIM_W-1:0]            csr_data
);

   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   cfg_type           cfg;
   logic              item_valid, item_pop;
   item_type          item;

   // csr beats are always taken; only known indexes touch state
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_index == REG_MAP_WIDTH) begin
         width_in = csr_data;
      end
      if (csr_valid && csr_index == REG_MAP_HEIGHT) begin
         height_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(MAP_DIM);
         height_ff <= DIM_W'(MAP_DIM);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // clamped map size plus a stale marker for the back engine
   always_comb begin
      cfg.width  = eff_dim(width_ff);
      cfg.height = eff_dim(height_ff);
      cfg.write  = csr_valid &&
                   (csr_index == REG_MAP_WIDTH || csr_index == REG_MAP_HEIGHT);
   end

   // front: input queue and command decode
   swrl_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .cmd(req_cmd), .col(req_col), .row(req_row),
      .tile_sea(req_tile_sea), .tile_land(req_tile_land),
      .item_valid(item_valid), .item(item), .item_pop(item_pop)
   );

   // back: map storage, relabel sequencer, query scans, result register
   swrl_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .item_valid(item_valid), .item(item), .item_pop(item_pop),
      .rsp_pop(pop), .rsp_empty(empty),
      .rsp_own_region(rsp_own_region), .rsp_window_region(rsp_window_region),
      .rsp_entry_found(rsp_entry_found), .rsp_entry_col(rsp_entry_col),
      .rsp_entry_row(rsp_entry_row)
   );

   // own tile sits inside the window, so a labelled own tile means a window hit
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_own_region[REGION_W-1]) |-> !rsp_window_region[REGION_W-1])
      else $error("own region labelled but window empty");

   // window lies inside the entry search
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_window_region[REGION_W-1]) |-> rsp_entry_found)
      else $error("window hit without entry");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_entry_found) |-> (rsp_entry_col == '0 && rsp_entry_row == '0))
      else $error("entry coordinates set without entry");

endmodule

// ----- sv/swrl_ram.sv -----
module swrl_ram #(
   parameter int DATA_W = 1,
   parameter int DEPTH  = 4096
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/swrl_front.sv -----
module swrl_front import swrl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 cmd,
   input  logic [COORD_W-1:0]   col,
   input  logic [COORD_W-1:0]   row,
   input  logic                 tile_sea,
   input  logic                 tile_land,
   output logic                 item_valid,
   output item_type             item,
   input  logic                 item_pop
);

   item_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;
   item_type            new_item;

   // classify the incoming beat
   always_comb begin
      new_item.op   = cmd ? OP_QUERY : OP_LOAD;
      new_item.col  = col;
      new_item.row  = row;
      new_item.sea  = tile_sea;
      new_item.land = tile_land;
   end

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = q_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= new_item;
      end
   end

endmodule

// ----- sv/swrl_back.sv -----
module swrl_back import swrl_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        item_valid,
   input  item_type                    item,
   output logic                        item_pop,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic signed [REGION_W-1:0]  rsp_own_region,
   output logic signed [REGION_W-1:0]  rsp_window_region,
   output logic                        rsp_entry_found,
   output logic [COORD_W-1:0]          rsp_entry_col,
   output logic [COORD_W-1:0]          rsp_entry_row
);

   state_type                  state_ff, state_in;
   logic                       stale_ff, stale_in;
   logic [REGION_W-1:0]        next_ff, next_in;
   logic [COORD_W-1:0]         qc_ff, qc_in, qr_ff, qr_in;
   logic [COORD_W-1:0]         tc_ff, tc_in, tr_ff, tr_in;
   logic signed [OFF_W-1:0]    offc_ff, offc_in, offr_ff, offr_in, rad_ff, rad_in;
   logic                       issue_ff, issue_in;
   pend_type                   pend_ff, pend_in;
   logic                       acc_ff, acc_in, sea_ff, sea_in;
   logic [REGION_W-1:0]        win_ff, win_in, own_ff, own_in;
   logic                       ef_ff, ef_in;
   logic [DIST_W-1:0]          eb_ff, eb_in;
   logic [COORD_W-1:0]         ec_ff, ec_in, er_ff, er_in;
   logic [PTR_W-1:0]           head_ff, head_in, tail_ff, tail_in;
   logic [ADDR_W-1:0]          t_ff, t_in;
   logic [1:0]                 k_ff, k_in;
   logic                       ov_ff, ov_in;
   logic [REGION_W-1:0]        oo_ff, oo_in, ow_ff, ow_in;
   logic                       of_ff, of_in;
   logic [COORD_W-1:0]         oc_ff, oc_in, or_ff, or_in;

   logic [DIM_W-1:0]           w, h;
   logic [COORD_W-1:0]         base_c, base_r;
   logic signed [POS_W-1:0]    pos_c, pos_r, nb_c, nb_r;
   logic                       scan_inmap, scan_last, nb_inmap, tile_last;
   logic [ADDR_W-1:0]          scan_addr, nb_addr, tile_addr;
   logic [OFF_W-1:0]           abs_c, abs_r;
   logic [1:0]                 tile_rd;
   logic [REGION_W:0]          reg_rd;
   logic [ADDR_W-1:0]          fq_rd;
   logic                       tile_we, reg_we, fq_we;
   logic [ADDR_W-1:0]          tile_wa, reg_wa, reg_ra, fq_wa;
   logic [1:0]                 tile_wd;
   logic [REGION_W:0]          reg_wd;
   logic [ADDR_W-1:0]          fq_wd;
   logic                       scan_done, lab, acc_new, sea_new, take, found_new;
   logic                       out_free, q_go, nb_new;

   assign w = cfg.width;
   assign h = cfg.height;

   // scan address generation around the base tile
   always_comb begin
      base_c     = (state_ff == S_SH) ? tc_ff : qc_ff;
      base_r     = (state_ff == S_SH) ? tr_ff : qr_ff;
      pos_c      = signed'({2'b00, base_c}) + POS_W'(offc_ff);
      pos_r      = signed'({2'b00, base_r}) + POS_W'(offr_ff);
      scan_inmap = pos_in_map(pos_c, pos_r, w, h);
      scan_addr  = {pos_r[COORD_W-1:0], pos_c[COORD_W-1:0]};
      scan_last  = (offc_ff == rad_ff) && (offr_ff == rad_ff);
      abs_c      = offc_ff[OFF_W-1] ? OFF_W'(-offc_ff) : OFF_W'(offc_ff);
      abs_r      = offr_ff[OFF_W-1] ? OFF_W'(-offr_ff) : OFF_W'(offr_ff);
      tile_last  = ({1'b0, tc_ff} == w - 1'b1) && ({1'b0, tr_ff} == h - 1'b1);
      tile_addr  = {tr_ff, tc_ff};
   end

   // 4-neighbor of the tile taken from the frontier
   always_comb begin
      nb_c = signed'({2'b00, t_ff[COORD_W-1:0]});
      nb_r = signed'({2'b00, t_ff[ADDR_W-1:COORD_W]});
      case (k_ff)
         2'd0:    nb_c = nb_c + 8'sd1;
         2'd1:    nb_c = nb_c - 8'sd1;
         2'd2:    nb_r = nb_r + 8'sd1;
         default: nb_r = nb_r - 8'sd1;
      endcase
      nb_inmap = pos_in_map(nb_c, nb_r, w, h);
      nb_addr  = {nb_r[COORD_W-1:0], nb_c[COORD_W-1:0]};
   end

   // consume side of the scan pipeline
   always_comb begin
      scan_done = !issue_ff && pend_ff.valid;
      lab       = pend_ff.valid && pend_ff.inmap && !reg_rd[REGION_W-1];
      acc_new   = acc_ff | (pend_ff.valid && pend_ff.inmap && tile_rd[0]);
      sea_new   = (pend_ff.valid && pend_ff.center) ? tile_rd[1] : sea_ff;
      take      = lab && (!ef_ff || (pend_ff.span < eb_ff));
      found_new = ef_ff || take;
      out_free  = !ov_ff || rsp_pop;
      q_go      = head_ff < tail_ff;
      nb_new    = reg_rd[REGION_W] && reg_rd[REGION_W-1];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (item_valid && item.op == OP_QUERY) begin
               state_in = stale_ff ? S_SH : S_WIN;
            end
         end
         S_SH: begin
            if (scan_done && tile_last) begin
               state_in = S_LB_RD;
            end
         end
         S_LB_RD:  state_in = S_LB_CHK;
         S_LB_CHK: begin
            if (reg_rd[REGION_W] && reg_rd[REGION_W-1]) begin
               state_in = S_Q_RD;
            end else begin
               state_in = tile_last ? S_WIN : S_LB_RD;
            end
         end
         S_Q_RD: begin
            if (q_go) begin
               state_in = S_Q_DAT;
            end else begin
               state_in = tile_last ? S_WIN : S_LB_RD;
            end
         end
         S_Q_DAT: state_in = S_NB_RD;
         S_NB_RD: begin
            if (nb_inmap) begin
               state_in = S_NB_CHK;
            end else if (k_ff == 2'd3) begin
               state_in = S_Q_RD;
            end
         end
         S_NB_CHK: state_in = (k_ff == 2'd3) ? S_Q_RD : S_NB_RD;
         S_WIN: begin
            if (scan_done) begin
               state_in = S_ENT;
            end
         end
         S_ENT: begin
            if (scan_done && (found_new || rad_ff == ENTRY_RADIUS)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      stale_in = stale_ff;  next_in = next_ff;
      qc_in = qc_ff;  qr_in = qr_ff;  tc_in = tc_ff;  tr_in = tr_ff;
      offc_in = offc_ff;  offr_in = offr_ff;  rad_in = rad_ff;  issue_in = issue_ff;
      pend_in = '0;
      acc_in = acc_ff;  sea_in = sea_ff;  win_in = win_ff;  own_in = own_ff;
      ef_in = ef_ff;  eb_in = eb_ff;  ec_in = ec_ff;  er_in = er_ff;
      head_in = head_ff;  tail_in = tail_ff;  t_in = t_ff;  k_in = k_ff;
      ov_in = ov_ff && !rsp_pop;
      oo_in = oo_ff;  ow_in = ow_ff;  of_in = of_ff;  oc_in = oc_ff;  or_in = or_ff;
      item_pop = 1'b0;
      tile_we = 1'b0;  tile_wa = {item.row, item.col};  tile_wd = {item.sea, item.land};
      reg_we = 1'b0;  reg_wa = tile_addr;  reg_wd = {1'b1, next_ff};  reg_ra = scan_addr;
      fq_we = 1'b0;  fq_wa = tail_ff[ADDR_W-1:0];  fq_wd = tile_addr;

      // issue side of the scan pipeline
      if ((state_ff == S_SH || state_ff == S_WIN || state_ff == S_ENT) && issue_ff) begin
         pend_in.valid  = 1'b1;
         pend_in.inmap  = scan_inmap;
         pend_in.center = (offc_ff == '0) && (offr_ff == '0);
         pend_in.span   = DIST_W'(abs_c + abs_r);
         pend_in.col    = pos_c[COORD_W-1:0];
         pend_in.row    = pos_r[COORD_W-1:0];
         if (scan_last) begin
            issue_in = 1'b0;
         end else if (offc_ff == rad_ff) begin
            offc_in = -rad_ff;
            offr_in = offr_ff + 1'b1;
         end else begin
            offc_in = offc_ff + 1'b1;
         end
      end

      if (cfg.write) begin
         stale_in = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.op == OP_LOAD) begin
                  tile_we  = 1'b1;
                  stale_in = 1'b1;
               end else begin
                  qc_in = item.col;  qr_in = item.row;
                  win_in = REGION_NONE;  own_in = REGION_NONE;
                  ef_in = 1'b0;  eb_in = '0;  ec_in = '0;  er_in = '0;
                  tc_in = '0;  tr_in = '0;  acc_in = 1'b0;  sea_in = 1'b0;
                  rad_in = stale_ff ? SHORE_REACH : WINDOW_REACH;
                  offc_in = stale_ff ? -SHORE_REACH : -WINDOW_REACH;
                  offr_in = stale_ff ? -SHORE_REACH : -WINDOW_REACH;
                  issue_in = 1'b1;
               end
            end
         end
         S_SH: begin
            acc_in = acc_new;
            sea_in = sea_new;
            if (scan_done) begin
               // shallow flag and cleared label for this tile
               reg_we = 1'b1;
               reg_wd = {sea_new && acc_new, REGION_NONE};
               acc_in = 1'b0;
               sea_in = 1'b0;
               if (tile_last) begin
                  tc_in = '0;  tr_in = '0;  next_in = '0;
               end else begin
                  if ({1'b0, tc_ff} == w - 1'b1) begin
                     tc_in = '0;  tr_in = tr_ff + 1'b1;
                  end else begin
                     tc_in = tc_ff + 1'b1;
                  end
                  offc_in = -SHORE_REACH;  offr_in = -SHORE_REACH;  issue_in = 1'b1;
               end
            end
         end
         S_LB_RD: reg_ra = tile_addr;
         S_LB_CHK, S_Q_RD: begin
            if (state_ff == S_LB_CHK && reg_rd[REGION_W] && reg_rd[REGION_W-1]) begin
               // seed a new region
               reg_we  = 1'b1;
               fq_we   = 1'b1;
               fq_wa   = '0;
               head_in = '0;
               tail_in = PTR_W'(1);
            end else if (state_ff == S_Q_RD && q_go) begin
               head_in = head_ff + 1'b1;
            end else begin
               if (state_ff == S_Q_RD && next_ff != REGION_MAX) begin
                  next_in = next_ff + 1'b1;
               end
               if (tile_last) begin
                  stale_in = 1'b0;
                  rad_in = WINDOW_REACH;  offc_in = -WINDOW_REACH;  offr_in = -WINDOW_REACH;
                  issue_in = 1'b1;
               end else if ({1'b0, tc_ff} == w - 1'b1) begin
                  tc_in = '0;  tr_in = tr_ff + 1'b1;
               end else begin
                  tc_in = tc_ff + 1'b1;
               end
            end
         end
         S_Q_DAT: begin
            t_in = fq_rd;
            k_in = '0;
         end
         S_NB_RD: begin
            reg_ra = nb_addr;
            if (!nb_inmap) begin
               k_in = k_ff + 1'b1;
            end
         end
         S_NB_CHK: begin
            if (nb_new) begin
               reg_we = 1'b1;
               reg_wa = nb_addr;
               if (tail_ff < PTR_W'(TILE_COUNT)) begin
                  fq_we   = 1'b1;
                  fq_wd   = nb_addr;
                  tail_in = tail_ff + 1'b1;
               end
            end
            k_in = k_ff + 1'b1;
         end
         S_WIN: begin
            if (lab && win_ff[REGION_W-1]) begin
               win_in = reg_rd[REGION_W-1:0];
            end
            if (pend_ff.valid && pend_ff.center) begin
               own_in = pend_ff.inmap ? reg_rd[REGION_W-1:0] : REGION_NONE;
            end
            if (scan_done) begin
               rad_in = 5'sd1;  offc_in = -5'sd1;  offr_in = -5'sd1;  issue_in = 1'b1;
            end
         end
         S_ENT: begin
            if (take) begin
               ef_in = 1'b1;  eb_in = pend_ff.span;
               ec_in = pend_ff.col;  er_in = pend_ff.row;
            end
            if (scan_done && !found_new && rad_ff != ENTRY_RADIUS) begin
               rad_in = rad_ff + 1'b1;
               offc_in = -(rad_ff + 1'b1);
               offr_in = -(rad_ff + 1'b1);
               issue_in = 1'b1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               ov_in = 1'b1;
               oo_in = own_ff;  ow_in = win_ff;  of_in = ef_ff;
               oc_in = ec_ff;  or_in = er_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stale_ff <= 1'b1;
         next_ff  <= '0;
         issue_ff <= 1'b0;
         pend_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         stale_ff <= stale_in;
         next_ff  <= next_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      qc_ff <= qc_in;  qr_ff <= qr_in;  tc_ff <= tc_in;  tr_ff <= tr_in;
      offc_ff <= offc_in;  offr_ff <= offr_in;  rad_ff <= rad_in;
      acc_ff <= acc_in;  sea_ff <= sea_in;  win_ff <= win_in;  own_ff <= own_in;
      ef_ff <= ef_in;  eb_ff <= eb_in;  ec_ff <= ec_in;  er_ff <= er_in;
      head_ff <= head_in;  tail_ff <= tail_in;  t_ff <= t_in;  k_ff <= k_in;
      oo_ff <= oo_in;  ow_ff <= ow_in;  of_ff <= of_in;  oc_ff <= oc_in;  or_ff <= or_in;
   end

   assign rsp_empty         = !ov_ff;
   assign rsp_own_region    = signed'(oo_ff);
   assign rsp_window_region = signed'(ow_ff);
   assign rsp_entry_found   = of_ff;
   assign rsp_entry_col     = oc_ff;
   assign rsp_entry_row     = or_ff;

   swrl_ram #(.DATA_W(2), .DEPTH(TILE_COUNT)) u_tile_ram (
      .clock(clock), .wr_en(tile_we), .wr_addr(tile_wa), .wr_data(tile_wd),
      .rd_addr(scan_addr), .rd_data(tile_rd)
   );

   swrl_ram #(.DATA_W(REGION_W + 1), .DEPTH(TILE_COUNT)) u_region_ram (
      .clock(clock), .wr_en(reg_we), .wr_addr(reg_wa), .wr_data(reg_wd),
      .rd_addr(reg_ra), .rd_data(reg_rd)
   );

   swrl_ram #(.DATA_W(ADDR_W), .DEPTH(TILE_COUNT)) u_frontier_ram (
      .clock(clock), .wr_en(fq_we), .wr_addr(fq_wa), .wr_data(fq_wd),
      .rd_addr(head_ff[ADDR_W-1:0]), .rd_data(fq_rd)
   );

endmodule

// ----- tb/shallow_water_region_labeler_top_test.sv -----
module shallow_water_region_labeler_top_test;
   import swrl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // csr indexes that no register answers to
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   // one query answer as seen on the rsp ports
   typedef struct packed {
      logic signed [REGION_W-1:0] own;
      logic signed [REGION_W-1:0] win;
      logic                       found;
      logic [COORD_W-1:0]         ecol;
      logic [COORD_W-1:0]         erow;
   } answer_type;

   // one row of the directed table, answer typed in only where obvious
   typedef struct packed {
      item_type   it;
      logic       typed;
      answer_type ans;
   } dir_row_type;

   logic                       clock;
   logic                       reset;
   logic                       push;
   logic                       full;
   logic                       req_cmd;
   logic [COORD_W-1:0]         req_col;
   logic [COORD_W-1:0]         req_row;
   logic                       req_tile_sea;
   logic                       req_tile_land;
   logic                       empty;
   logic                       pop;
   logic signed [REGION_W-1:0] rsp_own_region;
   logic signed [REGION_W-1:0] rsp_window_region;
   logic                       rsp_entry_found;
   logic [COORD_W-1:0]         rsp_entry_col;
   logic [COORD_W-1:0]         rsp_entry_row;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [DIM_W-1:0]           csr_data;

   shallow_water_region_labeler_top uut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ---------------------------------------------------------------
   // map model: tiles, labels and the raw register values
   // ---------------------------------------------------------------
   bit                         sea_tiles [TILE_COUNT];
   bit                         land_tiles[TILE_COUNT];
   logic signed [REGION_W-1:0] label_of  [TILE_COUNT];
   int                         fill_fifo [TILE_COUNT];
   bit                         labels_old;
   logic [DIM_W-1:0]           width_reg;
   logic [DIM_W-1:0]           height_reg;

   answer_type pending_answers[$];
   int         mismatches;
   int         answers_seen;

   function automatic int clamp_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAP_DIM) return MAP_DIM;
      return int'(v);
   endfunction

   function automatic bit on_map(int c, int r);
      return c >= 0 && r >= 0 && c < clamp_dim(width_reg) && r < clamp_dim(height_reg);
   endfunction

   function automatic bit is_shallow(int c, int r);
      if (!on_map(c, r) || !sea_tiles[r*MAP_DIM + c]) return 1'b0;
      for (int dr = -2; dr <= 2; dr++)
         for (int dc = -2; dc <= 2; dc++)
            if (on_map(c+dc, r+dr) && land_tiles[(r+dr)*MAP_DIM + c+dc]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic signed [REGION_W-1:0] region_of(int c, int r);
      if (!on_map(c, r)) return REGION_NONE;
      return label_of[r*MAP_DIM + c];
   endfunction

   // breadth-first flood fill, numbers in raster order of first tile
   function automatic void rebuild_labels();
      int head, tail, t, tc, tr, nc, nr, nxt;
      int step_c[4] = '{1, -1, 0, 0};
      int step_r[4] = '{0, 0, 1, -1};
      for (int i = 0; i < TILE_COUNT; i++) label_of[i] = REGION_NONE;
      nxt = 0;
      for (int r = 0; r < clamp_dim(height_reg); r++) begin
         for (int c = 0; c < clamp_dim(width_reg); c++) begin
            if (label_of[r*MAP_DIM + c] >= 0 || !is_shallow(c, r)) continue;
            label_of[r*MAP_DIM + c] = REGION_W'(nxt);
            head = 0;
            tail = 0;
            fill_fifo[tail++] = r*MAP_DIM + c;
            while (head < tail) begin
               t = fill_fifo[head++];
               tc = t % MAP_DIM;
               tr = t / MAP_DIM;
               for (int k = 0; k < 4; k++) begin
                  nc = tc + step_c[k];
                  nr = tr + step_r[k];
                  if (!on_map(nc, nr)) continue;
                  if (label_of[nr*MAP_DIM + nc] >= 0 || !is_shallow(nc, nr)) continue;
                  label_of[nr*MAP_DIM + nc] = REGION_W'(nxt);
                  if (tail < TILE_COUNT) fill_fifo[tail++] = nr*MAP_DIM + nc;
               end
            end
            if (nxt < 4095) nxt++;
         end
      end
      labels_old = 1'b0;
   endfunction

   // applies one beat to the map model; returns 1 when it yields an answer
   function automatic bit predict_tile_query(item_type it, output answer_type a);
      int c, r, best, score;
      logic signed [REGION_W-1:0] v;
      c = int'(it.col);
      r = int'(it.row);
      a = '0;
      if (it.op == OP_LOAD) begin
         sea_tiles[r*MAP_DIM + c]  = it.sea;
         land_tiles[r*MAP_DIM + c] = it.land;
         labels_old = 1'b1;
         return 1'b0;
      end
      if (labels_old) rebuild_labels();
      a.own = region_of(c, r);
      a.win = REGION_NONE;
      for (int dr = -2; dr <= 2 && a.win < 0; dr++)
         for (int dc = -2; dc <= 2 && a.win < 0; dc++) begin
            v = region_of(c+dc, r+dr);
            if (v >= 0) a.win = v;
         end
      // growing rings, nearest by manhattan, ties to scan order
      best = 1000000;
      for (int rad = 1; rad <= 4 && !a.found; rad++)
         for (int dr = -rad; dr <= rad; dr++)
            for (int dc = -rad; dc <= rad; dc++) begin
               if (region_of(c+dc, r+dr) < 0) continue;
               score = (dc < 0 ? -dc : dc) + (dr < 0 ? -dr : dr);
               if (score < best) begin
                  best   = score;
                  a.ecol = COORD_W'(c + dc);
                  a.erow = COORD_W'(r + dr);
                  a.found = 1'b1;
               end
            end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------
   int burst_left;

   // offers one beat, waits for it to be taken, then maybe opens a gap
   task automatic send_beat(item_type it, bit typed, answer_type typed_ans);
      answer_type a;
      push          <= 1'b1;
      req_cmd       <= it.op;
      req_col       <= it.col;
      req_row       <= it.row;
      req_tile_sea  <= it.sea;
      req_tile_land <= it.land;
      do @(posedge clock); while (full);
      if (predict_tile_query(it, a)) pending_answers.push_back(typed ? typed_ans : a);
      burst_left--;
      if (burst_left <= 0) begin
         push <= 1'b0;
         repeat ($urandom_range(0, 7) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 5))
            @(posedge clock);
         burst_left = $urandom_range(1, 14);
      end
   endtask

   task automatic send_item(item_type it);
      send_beat(it, 1'b0, '0);
   endtask

   // block is quiet: no answer owed, and trailing loads have drained
   task automatic wait_quiet();
      push <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_MAP_WIDTH) begin
         width_reg  = val;
         labels_old = 1'b1;
      end else if (idx == REG_MAP_HEIGHT) begin
         height_reg = val;
         labels_old = 1'b1;
      end
   endtask

   function automatic item_type mk_item(op_type op, int c, int r, bit s, bit l);
      item_type it;
      it.op   = op;
      it.col  = COORD_W'(c);
      it.row  = COORD_W'(r);
      it.sea  = s;
      it.land = l;
      return it;
   endfunction

   function automatic dir_row_type dir_row(op_type op, int c, int r, bit s, bit l, bit typed,
                                           int own, int win, bit f, int ec, int er);
      dir_row_type d;
      d.it        = mk_item(op, c, r, s, l);
      d.typed     = typed;
      d.ans.own   = REGION_W'(own);
      d.ans.win   = REGION_W'(win);
      d.ans.found = f;
      d.ans.ecol  = COORD_W'(ec);
      d.ans.erow  = COORD_W'(er);
      return d;
   endfunction

   // fresh random content over the whole map in use
   task automatic fill_map();
      for (int r = 0; r < clamp_dim(height_reg); r++)
         for (int c = 0; c < clamp_dim(width_reg); c++)
            send_item(mk_item(OP_LOAD, c, r, $urandom_range(0, 1),
                              $urandom_range(0, 9) < 3));
   endtask

   // mostly short load runs followed by queries; some stray loads
   // and queries anywhere in the 64x64 coordinate space
   task automatic random_groups(int count);
      int sent, w, h, n;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      sent = 0;
      while (sent < count) begin
         n = $urandom_range(0, 3);
         repeat (n) begin
            if ($urandom_range(0, 4) == 0)
               send_item(mk_item(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 1), $urandom_range(0, 1)));
            else
               send_item(mk_item(OP_LOAD, $urandom_range(0, w-1), $urandom_range(0, h-1),
                                 $urandom_range(0, 1), $urandom_range(0, 9) < 3));
            sent++;
         end
         if ($urandom_range(0, 9) == 0) continue;
         n = $urandom_range(1, 4);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0)
               send_item(mk_item(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 1), $urandom_range(0, 1)));
            else
               send_item(mk_item(OP_QUERY, $urandom_range(0, w-1), $urandom_range(0, h-1),
                                 $urandom_range(0, 1), $urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   task automatic run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int count);
      wait_quiet();
      csr_write(REG_MAP_WIDTH, w);
      csr_write(REG_MAP_HEIGHT, h);
      fill_map();
      random_groups(count);
   endtask

   // ---------------------------------------------------------------
   // receiver side: stall pattern rotates over steady, random and
   // sparse pops, plus one long hold that lets the input queue fill up and push back
   // ---------------------------------------------------------------
   int  rx_cycle;
   int  hold_left;
   bit  hold_done;

   always @(posedge clock) begin
      answer_type e;
      if (reset) begin
         pop <= 1'b0;
         rx_cycle  <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (pop && !empty) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
               $error("answer beat with nothing expected");
               mismatches++;
            end else begin
               e = pending_answers.pop_front();
               if (rsp_own_region !== e.own) begin
                  $error("own_region expected %0d got %0d", e.own, rsp_own_region);
                  mismatches++;
               end
               if (rsp_window_region !== e.win) begin
                  $error("window_region expected %0d got %0d", e.win, rsp_window_region);
                  mismatches++;
               end
               if (rsp_entry_found !== e.found) begin
                  $error("entry_found expected %0d got %0d", e.found, rsp_entry_found);
                  mismatches++;
               end
               if (rsp_entry_col !== e.ecol) begin
                  $error("entry_col expected %0d got %0d", e.ecol, rsp_entry_col);
                  mismatches++;
               end
               if (rsp_entry_row !== e.erow) begin
                  $error("entry_row expected %0d got %0d", e.erow, rsp_entry_row);
                  mismatches++;
               end
            end
         end
         if (!hold_done && answers_seen >= 150) begin
            // long hold while the sender keeps going
            hold_done <= 1'b1;
            hold_left <= 3000;
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
         end else begin
            case ((rx_cycle / 256) % 3)
               0: pop <= 1'b1;
               1: pop <= $urandom_range(0, 1);
               default: pop <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      dir_row_type rows[$];
      push          <= 1'b0;
      req_cmd       <= OP_LOAD;
      req_col       <= '0;
      req_row       <= '0;
      req_tile_sea  <= 1'b0;
      req_tile_land <= 1'b0;
      csr_valid     <= 1'b0;
      csr_index     <= REG_MAP_WIDTH;
      csr_data      <= '0;
      reset         <= 1'b1;
      mismatches    = 0;
      answers_seen  = 0;
      burst_left    = 1;
      for (int i = 0; i < TILE_COUNT; i++) begin
         sea_tiles[i]  = 1'b0;
         land_tiles[i] = 1'b0;
         label_of[i]   = REGION_NONE;
      end
      labels_old = 1'b1;
      width_reg  = 7'd64;
      height_reg = 7'd64;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on a 3x3 map
      csr_write(REG_MAP_WIDTH, 7'd3);
      csr_write(REG_MAP_HEIGHT, 7'd3);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            rows.push_back(dir_row(OP_LOAD, c, r, 0, 1, 0, 0, 0, 0, 0, 0));
      // all land, no water: nothing labelled
      rows.push_back(dir_row(OP_QUERY, 0, 0, 0, 0, 1, -1, -1, 0, 0, 0));
      // far corner, outside the map
      rows.push_back(dir_row(OP_QUERY, 63, 63, 1, 1, 1, -1, -1, 0, 0, 0));
      // single water tile next to land becomes region 0
      rows.push_back(dir_row(OP_LOAD, 2, 2, 1, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_QUERY, 2, 2, 0, 0, 1, 0, 0, 1, 2, 2));
      rows.push_back(dir_row(OP_LOAD, 1, 2, 1, 1, 0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // stored outside the map in use
      rows.push_back(dir_row(OP_LOAD, 63, 63, 1, 1, 0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_QUERY, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_LOAD, 2, 1, 1, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_LOAD, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_QUERY, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_QUERY, 0, 63, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_QUERY, 4, 4, 0, 0, 0, 0, 0, 0, 0, 0));
      foreach (rows[i]) send_beat(rows[i].it, rows[i].typed, rows[i].ans);

      // unknown indexes are dropped by the block
      wait_quiet();
      csr_write(REG_SPARE_2, 7'h7f);
      csr_write(REG_SPARE_3, 7'h2a);
      random_groups(40);

      // random phases: zero clamps to 1, large values clamp to 64
      run_phase(7'd0, 7'd0, 40);
      run_phase(7'd100, 7'd1, 120);
      run_phase(7'd1, 7'd127, 120);
      run_phase(7'd5, 7'd4, 150);
      run_phase(7'd7, 7'd6, 150);
      run_phase(7'd8, 7'd8, 140);
      run_phase(7'd6, 7'd3, 110);

      // full-width map, one rebuild and a few queries
      wait_quiet();
      csr_write(REG_MAP_WIDTH, 7'd64);
      csr_write(REG_MAP_HEIGHT, 7'd2);
      fill_map();
      repeat (12)
         send_item(mk_item(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0));

      push <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("shallow_water_region_labeler_top regression: pass");
      end else begin
         $display("shallow_water_region_labeler_top regression: fail");
      end
      $finish;
   end

   // watchdog, well past the slowest legal run
   initial begin
      #80ms;
      $display("shallow_water_region_labeler_top regression: fail");
      $finish;
   end

endmodule
